>>> src/fsbh_pkg.sv
package fsbh_pkg;

	localparam int BYTE_W = 8;
	localparam int OCC_W  = 32;
	localparam int DIST_W = 9;

	typedef logic [1:0] action_t;

	localparam action_t ACT_FEED  = 2'd0;
	localparam action_t ACT_READ  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

endpackage

>>> src/fsbh_ram.sv
module fsbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/first_seen_byte_histogram.sv
// Clear, unknown action, new byte, dropped byte and unfilled-slot read finish from idle; a
// read of a filled slot goes through FETCH; a byte seen before goes through LOOK and FETCH
// (two dependent reads of the slot-of-byte and slot memories, then the count write-back).
// A new item is taken only in idle; busy is high while an item is in flight.
// Reset clears the seen bits and the distinct count at once; no clearing pass is needed.
// done is a one-cycle strobe; the receiver cannot stall it.
module first_seen_byte_histogram
	import fsbh_pkg::*;
#(
	parameter int MAX_DISTINCT = 256,
	parameter int COUNT_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic [BYTE_W-1:0] slot,
	output logic              done,
	output logic [BYTE_W-1:0] slot_index,
	output logic [BYTE_W-1:0] character,
	output logic [OCC_W-1:0]  occurrences,
	output logic              is_new,
	output logic              valid_res,
	output logic [DIST_W-1:0] distinct
);

	localparam int SLOT_AW = $clog2(MAX_DISTINCT);
	localparam int ENTRY_W = BYTE_W + COUNT_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FETCH
	} state_t;

	state_t state_q;

	logic [255:0]         seen_q;
	logic [DIST_W-1:0]    distinct_q;
	logic                 feed_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [SLOT_AW-1:0]   k_q;

	logic                 done_q;
	logic [BYTE_W-1:0]    slot_index_q;
	logic [BYTE_W-1:0]    character_q;
	logic [OCC_W-1:0]     occurrences_q;
	logic                 is_new_q;
	logic                 valid_res_q;

	logic                 accept;
	logic                 room;
	logic                 slot_filled;

	logic                 sob_we;
	logic [SLOT_AW-1:0]   sob_rdata;

	logic                 ent_we;
	logic [SLOT_AW-1:0]   ent_waddr;
	logic [ENTRY_W-1:0]   ent_wdata;
	logic [SLOT_AW-1:0]   ent_raddr;
	logic [ENTRY_W-1:0]   ent_rdata;

	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_sel;
	logic [63:0]           occ_wide;
	logic [OCC_W-1:0]      occ_clip;

	assign accept      = start && (state_q == ST_IDLE);
	assign room        = distinct_q < DIST_W'(MAX_DISTINCT);
	assign slot_filled = {1'b0, slot} < distinct_q;

	always_comb begin
		sob_we    = accept && (action == ACT_FEED) && !seen_q[byte_value] && room;
		ent_raddr = (state_q == ST_IDLE) ? slot[SLOT_AW-1:0] : sob_rdata;
		ent_we    = sob_we || (state_q == ST_FETCH && feed_q);
		cnt_cur   = ent_rdata[COUNT_BITS-1:0];
		// hold at the top of the count range
		cnt_inc   = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
		if (state_q == ST_FETCH) begin
			ent_waddr = k_q;
			ent_wdata = {byte_q, cnt_inc};
		end else begin
			ent_waddr = distinct_q[SLOT_AW-1:0];
			ent_wdata = {byte_value, COUNT_BITS'(1)};
		end
		cnt_sel  = feed_q ? cnt_inc : cnt_cur;
		occ_wide = 64'(cnt_sel);
		occ_clip = (|occ_wide[63:OCC_W]) ? '1 : occ_wide[OCC_W-1:0];
	end

	fsbh_ram #(
		.WIDTH(SLOT_AW),
		.DEPTH(256)
	) u_slot_of_byte (
		.clk  (clk),
		.we   (sob_we),
		.waddr(byte_value),
		.wdata(distinct_q[SLOT_AW-1:0]),
		.raddr(byte_value),
		.rdata(sob_rdata)
	);

	fsbh_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_DISTINCT)
	) u_entry (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			seen_q        <= '0;
			distinct_q    <= '0;
			feed_q        <= 1'b0;
			done_q        <= 1'b0;
			byte_q        <= '0;
			k_q           <= '0;
			slot_index_q  <= '0;
			character_q   <= '0;
			occurrences_q <= '0;
			is_new_q      <= 1'b0;
			valid_res_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						byte_q        <= byte_value;
						k_q           <= slot[SLOT_AW-1:0];
						feed_q        <= (action == ACT_FEED);
						slot_index_q  <= '0;
						character_q   <= '0;
						occurrences_q <= '0;
						is_new_q      <= 1'b0;
						valid_res_q   <= 1'b0;
						unique case (action)
							ACT_FEED: begin
								if (seen_q[byte_value]) begin
									state_q <= ST_LOOK;
								end else if (room) begin
									seen_q[byte_value] <= 1'b1;
									distinct_q         <= distinct_q + DIST_W'(1);
									slot_index_q       <= BYTE_W'(distinct_q[SLOT_AW-1:0]);
									character_q        <= byte_value;
									occurrences_q      <= OCC_W'(1);
									is_new_q           <= 1'b1;
									valid_res_q        <= 1'b1;
									done_q             <= 1'b1;
								end else begin
									// table full: drop the byte
									character_q <= byte_value;
									done_q      <= 1'b1;
								end
							end
							ACT_READ: begin
								slot_index_q <= slot;
								if (slot_filled) begin
									state_q <= ST_FETCH;
								end else begin
									done_q <= 1'b1;
								end
							end
							ACT_CLEAR: begin
								seen_q     <= '0;
								distinct_q <= '0;
								done_q     <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_LOOK: begin
					k_q     <= sob_rdata;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					slot_index_q  <= BYTE_W'(k_q);
					character_q   <= feed_q ? byte_q : ent_rdata[ENTRY_W-1:COUNT_BITS];
					occurrences_q <= occ_clip;
					valid_res_q   <= 1'b1;
					done_q        <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign slot_index  = slot_index_q;
	assign character   = character_q;
	assign occurrences = occurrences_q;
	assign is_new      = is_new_q;
	assign valid_res   = valid_res_q;
	assign distinct    = distinct_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result beat while an item is still in flight");

	a_distinct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		distinct_q <= DIST_W'(MAX_DISTINCT))
		else $error("distinct count beyond table size");

	a_new_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_new) |-> (valid_res && occurrences == OCC_W'(1)))
		else $error("new byte without a valid first count");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_CLEAR) |=> (done && distinct_q == '0 && seen_q == '0))
		else $error("clear did not empty the table");

	a_distinct_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (distinct_q == $past(distinct_q) || distinct_q == $past(distinct_q) + DIST_W'(1)
			|| distinct_q == '0))
		else $error("distinct count moved by more than one");

endmodule

>>> tb/tb_first_seen_byte_histogram.sv
module tb_first_seen_byte_histogram;
	import fsbh_pkg::*;

	localparam int MAX_DIST   = 256;
	localparam int IDLE_LIMIT = 500;
	localparam int ROUND_LEN  = 30;
	localparam action_t ACT_NONE = 2'd3;
	localparam logic [OCC_W-1:0] OCC_MAX = '1;

	typedef struct packed {
		logic [BYTE_W-1:0] slot_index;
		logic [BYTE_W-1:0] character;
		logic [OCC_W-1:0]  occurrences;
		logic              is_new;
		logic              valid_res;
		logic [DIST_W-1:0] distinct;
	} hist_res_t;

	typedef struct packed {
		action_t           act;
		logic [BYTE_W-1:0] byte_value;
		logic [BYTE_W-1:0] slot;
		logic              typed;
		hist_res_t         want;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        action;
	logic [BYTE_W-1:0] byte_value;
	logic [BYTE_W-1:0] slot;
	logic              done;
	logic [BYTE_W-1:0] slot_index;
	logic [BYTE_W-1:0] character;
	logic [OCC_W-1:0]  occurrences;
	logic              is_new;
	logic              valid_res;
	logic [DIST_W-1:0] distinct;

	first_seen_byte_histogram #(
		.MAX_DISTINCT(MAX_DIST),
		.COUNT_BITS  (OCC_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.byte_value (byte_value),
		.slot       (slot),
		.done       (done),
		.slot_index (slot_index),
		.character  (character),
		.occurrences(occurrences),
		.is_new     (is_new),
		.valid_res  (valid_res),
		.distinct   (distinct)
	);

	// predictor state
	logic [255:0]      seen_bits;
	logic [BYTE_W-1:0] slot_of_byte_m [256];
	logic [BYTE_W-1:0] byte_of_slot_m [256];
	logic [OCC_W-1:0]  count_of_slot_m [256];
	int unsigned       held_distinct;

	hist_res_t tally_q[$];
	hist_res_t got_res;
	int n_errors;
	int n_sent;
	int n_checked;
	int n_clears;
	int peak_distinct;
	int gap_max;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic predict_histogram(input action_t a, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] s, output hist_res_t r);
		logic [BYTE_W-1:0] k;
		r = '0;
		case (a)
			ACT_FEED: begin
				r.character = b;
				if (seen_bits[b]) begin
					k = slot_of_byte_m[b];
					if (count_of_slot_m[k] != OCC_MAX)
						count_of_slot_m[k] = count_of_slot_m[k] + 1;
					r.slot_index  = k;
					r.occurrences = count_of_slot_m[k];
					r.valid_res   = 1'b1;
				end else if (held_distinct < MAX_DIST) begin
					k = held_distinct[BYTE_W-1:0];
					seen_bits[b]       = 1'b1;
					slot_of_byte_m[b]  = k;
					byte_of_slot_m[k]  = b;
					count_of_slot_m[k] = 1;
					held_distinct++;
					r.slot_index  = k;
					r.occurrences = 1;
					r.is_new      = 1'b1;
					r.valid_res   = 1'b1;
				end
				// table full: drop the byte, report it with nothing else
			end
			ACT_READ: begin
				r.slot_index = s;
				if (s < held_distinct) begin
					r.character   = byte_of_slot_m[s];
					r.occurrences = count_of_slot_m[s];
					r.valid_res   = 1'b1;
				end
			end
			ACT_CLEAR: begin
				seen_bits     = '0;
				held_distinct = 0;
				n_clears++;
			end
			default: ;
		endcase
		r.distinct = held_distinct[DIST_W-1:0];
		if (held_distinct > peak_distinct)
			peak_distinct = held_distinct;
	endtask

	// present one beat at the falling edge, hold it until the block takes it
	task automatic send_beat(input stim_row_t row);
		int gap;
		hist_res_t predicted;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		action     = row.act;
		byte_value = row.byte_value;
		slot       = row.slot;
		start      = 1'b1;
		do @(posedge clk); while (busy);
		predict_histogram(row.act, row.byte_value, row.slot, predicted);
		tally_q.push_back(row.typed ? row.want : predicted);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic compare_result(input hist_res_t got, input hist_res_t want);
		if (got.slot_index !== want.slot_index)
			flag_error($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
		if (got.character !== want.character)
			flag_error($sformatf("character %02h, want %02h", got.character, want.character));
		if (got.occurrences !== want.occurrences)
			flag_error($sformatf("occurrences %0d, want %0d",
				got.occurrences, want.occurrences));
		if (got.is_new !== want.is_new)
			flag_error($sformatf("is_new %b, want %b", got.is_new, want.is_new));
		if (got.valid_res !== want.valid_res)
			flag_error($sformatf("valid_res %b, want %b", got.valid_res, want.valid_res));
		if (got.distinct !== want.distinct)
			flag_error($sformatf("distinct %0d, want %0d", got.distinct, want.distinct));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			got_res = '{slot_index, character, occurrences, is_new, valid_res, distinct};
			if (tally_q.size() == 0) begin
				flag_error("result with nothing expected");
			end else begin
				compare_result(got_res, tally_q.pop_front());
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	stim_row_t dir_rows [22] = '{
		'{ACT_READ,  8'h00, 8'h00, 1'b1, '{8'd0,   8'h00, 32'd0, 1'b0, 1'b0, 9'd0}},
		'{ACT_READ,  8'h00, 8'hff, 1'b1, '{8'd255, 8'h00, 32'd0, 1'b0, 1'b0, 9'd0}},
		// NUL is an ordinary byte
		'{ACT_FEED,  8'h00, 8'h00, 1'b1, '{8'd0,   8'h00, 32'd1, 1'b1, 1'b1, 9'd1}},
		'{ACT_FEED,  8'h00, 8'h00, 1'b1, '{8'd0,   8'h00, 32'd2, 1'b0, 1'b1, 9'd1}},
		'{ACT_FEED,  8'hff, 8'h00, 1'b1, '{8'd1,   8'hff, 32'd1, 1'b1, 1'b1, 9'd2}},
		'{ACT_FEED,  8'hff, 8'h00, 1'b0, '0},
		'{ACT_FEED,  8'h00, 8'h00, 1'b0, '0},
		'{ACT_READ,  8'h00, 8'h00, 1'b0, '0},
		'{ACT_READ,  8'h00, 8'h01, 1'b0, '0},
		'{ACT_READ,  8'h00, 8'h02, 1'b1, '{8'd2,   8'h00, 32'd0, 1'b0, 1'b0, 9'd2}},
		'{ACT_NONE,  8'h00, 8'h00, 1'b1, '{8'd0,   8'h00, 32'd0, 1'b0, 1'b0, 9'd2}},
		'{ACT_FEED,  8'ha5, 8'h00, 1'b0, '0},
		'{ACT_FEED,  8'h5a, 8'h00, 1'b0, '0},
		'{ACT_FEED,  8'ha5, 8'h00, 1'b0, '0},
		'{ACT_READ,  8'h00, 8'h02, 1'b0, '0},
		'{ACT_READ,  8'h00, 8'h03, 1'b0, '0},
		'{ACT_CLEAR, 8'hff, 8'hff, 1'b1, '{8'd0,   8'h00, 32'd0, 1'b0, 1'b0, 9'd0}},
		'{ACT_READ,  8'h00, 8'h00, 1'b1, '{8'd0,   8'h00, 32'd0, 1'b0, 1'b0, 9'd0}},
		'{ACT_FEED,  8'hff, 8'h00, 1'b1, '{8'd0,   8'hff, 32'd1, 1'b1, 1'b1, 9'd1}},
		'{ACT_FEED,  8'h00, 8'h00, 1'b1, '{8'd1,   8'h00, 32'd1, 1'b1, 1'b1, 9'd2}},
		'{ACT_READ,  8'h00, 8'h01, 1'b0, '0},
		'{ACT_NONE,  8'hff, 8'hff, 1'b1, '{8'd0,   8'h00, 32'd0, 1'b0, 1'b0, 9'd2}}
	};

	initial begin
		stim_row_t row;
		logic [BYTE_W-1:0] sweep_order [256];
		logic [BYTE_W-1:0] tmp;
		int j;
		int pick;
		int hi;

		arst_n        = 1'b0;
		start         = 1'b0;
		action        = ACT_FEED;
		byte_value    = '0;
		slot          = '0;
		seen_bits     = '0;
		held_distinct = 0;
		n_errors      = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_clears      = 0;
		peak_distinct = 0;
		gap_max       = 9;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_beat(dir_rows[i]);

		for (int round = 0; round < 4; round++) begin
			gap_max = (round == 1) ? 0 : ((round == 3) ? 3 : 9);
			if (round == 2) begin
				// clear, then fill every slot in a shuffled order
				for (int i = 0; i < 256; i++)
					sweep_order[i] = i[BYTE_W-1:0];
				for (int i = 255; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp            = sweep_order[i];
					sweep_order[i] = sweep_order[j];
					sweep_order[j] = tmp;
				end
				row = '0;
				row.act = ACT_CLEAR;
				send_beat(row);
				for (int i = 0; i < 256; i++) begin
					row = '0;
					row.act        = ACT_FEED;
					row.byte_value = sweep_order[i];
					send_beat(row);
				end
				row = '0;
				row.act  = ACT_READ;
				row.slot = 8'hff;
				send_beat(row);
			end
			repeat (ROUND_LEN) begin
				row  = '0;
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					row.act = ACT_FEED;
					// a narrow range half the time so counts climb
					row.byte_value = BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
						: $urandom_range(0, 255));
				end else if (pick < 92) begin
					row.act = ACT_READ;
					hi = (held_distinct + 2 > 255) ? 255 : held_distinct + 2;
					row.slot = BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, hi)
						: $urandom_range(0, 255));
				end else if (pick < 96) begin
					row.act = ACT_CLEAR;
				end else begin
					row.act = ACT_NONE;
				end
				if (row.act != ACT_FEED)
					row.byte_value = BYTE_W'($urandom_range(0, 255));
				if (row.act != ACT_READ)
					row.slot = BYTE_W'($urandom_range(0, 255));
				send_beat(row);
			end
		end

		start = 1'b0;
		while (tally_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d beats (%0d clears), checked %0d results", n_sent, n_clears,
			n_checked);
		$display("peak distinct bytes %0d, full table sweep included", peak_distinct);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
